// ===== design/bwam_pkg.sv =====
// ----------------------------------------------------------------------------
// Battery window average monitor - shared definitions
// Widths, reset values, register indexes, status codes and pipeline control.
// ----------------------------------------------------------------------------
`default_nettype none

package bwam_pkg;

    // Sample and result widths
    localparam int SAMPLE_W    = 8;
    localparam int MV_W        = 16;
    localparam int DIFF_W      = MV_W + 1;
    localparam int CFG_INDEX_W = 8;

    // Fixed rotation pack, cell 1, boost
    localparam int CHANNEL_COUNT = 3;
    localparam int CH_W          = $clog2(CHANNEL_COUNT);
    localparam logic [CH_W-1:0] CH_PACK  = CH_W'(0);
    localparam logic [CH_W-1:0] CH_CELL  = CH_W'(1);
    localparam logic [CH_W-1:0] CH_BOOST = CH_W'(2);
    localparam logic [CH_W-1:0] CH_LAST  = CH_W'(CHANNEL_COUNT - 1);

    // Samples kept per channel
    localparam int WINDOW_LEN_DEFAULT = 64;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_PACK_FS  = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] REG_BOOST_FS = CFG_INDEX_W'(1);
    localparam logic [CFG_INDEX_W-1:0] REG_OVER_LIM = CFG_INDEX_W'(2);
    localparam logic [CFG_INDEX_W-1:0] REG_LOW_LIM  = CFG_INDEX_W'(3);

    // Register reset values
    localparam logic [MV_W-1:0] PACK_FS_RESET  = MV_W'(9900);
    localparam logic [MV_W-1:0] BOOST_FS_RESET = MV_W'(18810);
    localparam logic [MV_W-1:0] OVER_LIM_RESET = MV_W'(4200);
    localparam logic [MV_W-1:0] LOW_LIM_RESET  = MV_W'(3300);

    // Status codes
    typedef enum logic [1:0] {
        STATUS_OK   = 2'd0,
        STATUS_OVER = 2'd1,
        STATUS_LOW  = 2'd2
    } status_t;

    // Load strobes for the scaling stages
    typedef struct packed {
        logic load_avg;
        logic load_mv;
    } pipe_ctrl_t;

endpackage

`default_nettype wire

// ===== design/battery_window_average_monitor.sv =====
// ----------------------------------------------------------------------------
// Battery window average monitor
// Moving average over the last WINDOW_LEN samples of three interleaved
// converter channels, scaled to millivolts, with a cell voltage check.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake             Payload
//  in        input      in_valid / in_stall   sample
//  out       output     out_valid / out_stall pack_mv, cell_one_mv,
//                                             cell_two_mv, boost_mv, status
//  cfg       input      cfg_valid / cfg_ready cfg_index, cfg_data
//
//  One sample word is taken per clock unless in_stall; each gives one result
//  word via sum snapshot, average multiply, scale multiply and output regs.
//  Throughput is set by the running-sum update, one sample per cycle unless stalled.
//  Stages collapse bubbles, so a new word is taken while a result waits.
//  Reset clears the window chain, sums, channel pointer and all valids.
//  cfg_ready is always high; writes are expected only while idle.
// ----------------------------------------------------------------------------
`default_nettype none

module battery_window_average_monitor
#(
    parameter int WINDOW_LEN = bwam_pkg::WINDOW_LEN_DEFAULT
)
(
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    // sample input
    input  wire logic                               in_valid,
    output logic                                    in_stall,
    input  wire logic [bwam_pkg::SAMPLE_W-1:0]      sample,
    // result output
    output logic                                    out_valid,
    input  wire logic                               out_stall,
    output logic      [bwam_pkg::MV_W-1:0]          pack_mv,
    output logic      [bwam_pkg::MV_W-1:0]          cell_one_mv,
    output logic signed [bwam_pkg::DIFF_W-1:0]      cell_two_mv,
    output logic      [bwam_pkg::MV_W-1:0]          boost_mv,
    output logic      [1:0]                         status,
    // configuration
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [bwam_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  wire logic [bwam_pkg::MV_W-1:0]          cfg_data
);

    localparam int CHN      = bwam_pkg::CHANNEL_COUNT;
    localparam int CH_W     = bwam_pkg::CH_W;
    localparam int MV_W     = bwam_pkg::MV_W;
    localparam int DIFF_W   = bwam_pkg::DIFF_W;
    localparam int SUM_W    = bwam_pkg::SAMPLE_W + $clog2(WINDOW_LEN);
    localparam int DEPTH    = CHN * WINDOW_LEN;
    localparam int SUM_MAX  = ((1 << bwam_pkg::SAMPLE_W) - 1) * WINDOW_LEN;

    // configuration registers
    logic [MV_W-1:0] pack_fs_reg;
    logic [MV_W-1:0] boost_fs_reg;
    logic [MV_W-1:0] over_lim_reg;
    logic [MV_W-1:0] low_lim_reg;

    // running state
    logic [CH_W-1:0]  ch_reg;
    logic [CH_W-1:0]  ch_next;
    logic [SUM_W-1:0] sum_reg [CHN];
    logic [SUM_W-1:0] sum_next;
    logic [bwam_pkg::SAMPLE_W-1:0] oldest;

    // pipeline
    logic             v1_reg, v2_reg, v3_reg, out_valid_reg;
    logic             ready1, ready2, ready3, ready4;
    logic             accept, adv_out;
    logic [SUM_W-1:0] snap_reg [CHN];
    logic [MV_W-1:0]  mv [CHN];
    bwam_pkg::pipe_ctrl_t pctrl;

    // output stage
    logic signed [DIFF_W-1:0] diff;
    logic signed [DIFF_W-1:0] cell_s, over_s, low_s;
    bwam_pkg::status_t        status_next;
    logic [MV_W-1:0]          pack_mv_reg, cell_one_mv_reg, boost_mv_reg;
    logic signed [DIFF_W-1:0] cell_two_mv_reg;
    bwam_pkg::status_t        status_reg;

    // ------------------------------------------------------------------
    // Configuration writes
    // ------------------------------------------------------------------
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pack_fs_reg  <= bwam_pkg::PACK_FS_RESET;
            boost_fs_reg <= bwam_pkg::BOOST_FS_RESET;
            over_lim_reg <= bwam_pkg::OVER_LIM_RESET;
            low_lim_reg  <= bwam_pkg::LOW_LIM_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                bwam_pkg::REG_PACK_FS:  pack_fs_reg  <= cfg_data;
                bwam_pkg::REG_BOOST_FS: boost_fs_reg <= cfg_data;
                bwam_pkg::REG_OVER_LIM: over_lim_reg <= cfg_data;
                bwam_pkg::REG_LOW_LIM:  low_lim_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Handshake and stage advance
    // ------------------------------------------------------------------
    assign ready4   = !out_valid_reg || !out_stall;
    assign ready3   = !v3_reg || ready4;
    assign ready2   = !v2_reg || ready3;
    assign ready1   = !v1_reg || ready2;
    assign accept   = in_valid && ready1;
    assign in_stall = !ready1;
    assign adv_out  = v3_reg && ready4;
    assign pctrl.load_avg = v1_reg && ready2;
    assign pctrl.load_mv  = v2_reg && ready3;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
                v1_reg <= 1'b1;
            else if (pctrl.load_avg)
                v1_reg <= 1'b0;

            if (pctrl.load_avg)
                v2_reg <= 1'b1;
            else if (pctrl.load_mv)
                v2_reg <= 1'b0;

            if (pctrl.load_mv)
                v3_reg <= 1'b1;
            else if (adv_out)
                v3_reg <= 1'b0;

            if (adv_out)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Window chain: the far end leaves the current channel's sum
    // ------------------------------------------------------------------
    bwam_chain #(.DEPTH(DEPTH)) u_chain
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .shift_en  (accept),
        .sample_in (sample),
        .oldest    (oldest)
    );

    // ------------------------------------------------------------------
    // Running sums and channel rotation
    // ------------------------------------------------------------------
    assign sum_next = sum_reg[ch_reg] - SUM_W'(oldest) + SUM_W'(sample);
    assign ch_next  = (ch_reg == bwam_pkg::CH_LAST) ? bwam_pkg::CH_PACK
                                                    : ch_reg + CH_W'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ch_reg <= bwam_pkg::CH_PACK;
            for (int i = 0; i < CHN; i++)
                sum_reg[i] <= '0;
        end
        else if (accept)
        begin
            ch_reg          <= ch_next;
            sum_reg[ch_reg] <= sum_next;
        end
    end

    // snapshot of all sums after this word
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            for (int i = 0; i < CHN; i++)
                snap_reg[i] <= (CH_W'(i) == ch_reg) ? sum_next : sum_reg[i];
        end
    end

    // ------------------------------------------------------------------
    // Average and millivolt scaling per channel
    // ------------------------------------------------------------------
    bwam_scale #(.WINDOW_LEN(WINDOW_LEN), .SUM_W(SUM_W)) u_scale_pack
    (
        .clk        (clk),
        .ctrl       (pctrl),
        .sum        (snap_reg[bwam_pkg::CH_PACK]),
        .full_scale (pack_fs_reg),
        .mv         (mv[bwam_pkg::CH_PACK])
    );

    bwam_scale #(.WINDOW_LEN(WINDOW_LEN), .SUM_W(SUM_W)) u_scale_cell
    (
        .clk        (clk),
        .ctrl       (pctrl),
        .sum        (snap_reg[bwam_pkg::CH_CELL]),
        .full_scale (pack_fs_reg),
        .mv         (mv[bwam_pkg::CH_CELL])
    );

    bwam_scale #(.WINDOW_LEN(WINDOW_LEN), .SUM_W(SUM_W)) u_scale_boost
    (
        .clk        (clk),
        .ctrl       (pctrl),
        .sum        (snap_reg[bwam_pkg::CH_BOOST]),
        .full_scale (boost_fs_reg),
        .mv         (mv[bwam_pkg::CH_BOOST])
    );

    // ------------------------------------------------------------------
    // Cell 2 and status; over voltage takes priority
    // ------------------------------------------------------------------
    assign cell_s = $signed({1'b0, mv[bwam_pkg::CH_CELL]});
    assign over_s = $signed({1'b0, over_lim_reg});
    assign low_s  = $signed({1'b0, low_lim_reg});
    assign diff   = $signed({1'b0, mv[bwam_pkg::CH_PACK]}) - cell_s;

    always_comb
    begin
        if (cell_s > over_s || diff > over_s)
            status_next = bwam_pkg::STATUS_OVER;
        else if (cell_s < low_s || diff < low_s)
            status_next = bwam_pkg::STATUS_LOW;
        else
            status_next = bwam_pkg::STATUS_OK;
    end

    always_ff @(posedge clk)
    begin
        if (adv_out)
        begin
            pack_mv_reg     <= mv[bwam_pkg::CH_PACK];
            cell_one_mv_reg <= mv[bwam_pkg::CH_CELL];
            cell_two_mv_reg <= diff;
            boost_mv_reg    <= mv[bwam_pkg::CH_BOOST];
            status_reg      <= status_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign pack_mv     = pack_mv_reg;
    assign cell_one_mv = cell_one_mv_reg;
    assign cell_two_mv = cell_two_mv_reg;
    assign boost_mv    = boost_mv_reg;
    assign status      = status_reg;

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
    // rotation steps once per word taken
    a_rotation: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> ch_reg == (($past(ch_reg) == bwam_pkg::CH_LAST) ?
                              bwam_pkg::CH_PACK : $past(ch_reg) + CH_W'(1)))
        else $error("channel pointer did not advance");

    // a sum never exceeds a full window of full-code samples
    a_sum_bound: assert property (@(posedge clk) disable iff (!rst_n)
        sum_reg[bwam_pkg::CH_PACK] <= SUM_W'(SUM_MAX) &&
        sum_reg[bwam_pkg::CH_CELL] <= SUM_W'(SUM_MAX) &&
        sum_reg[bwam_pkg::CH_BOOST] <= SUM_W'(SUM_MAX))
        else $error("running sum out of range");

    // a full, stalled pipeline takes no word
    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall && v1_reg && v2_reg && v3_reg) |-> in_stall)
        else $error("word taken into a full pipeline");

    // cell 2 agrees with the two reported cells
    a_cell_two: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> cell_two_mv_reg ==
            $signed({1'b0, pack_mv_reg}) - $signed({1'b0, cell_one_mv_reg}))
        else $error("cell 2 mismatch");

endmodule

`default_nettype wire

// ===== design/bwam_cell.sv =====
// ----------------------------------------------------------------------------
// Window cell
// Holds one sample byte and passes it to the next cell on every word taken.
// ----------------------------------------------------------------------------
`default_nettype none

module bwam_cell
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           shift_en,
    input  wire logic [bwam_pkg::SAMPLE_W-1:0]  d,
    output logic      [bwam_pkg::SAMPLE_W-1:0]  q
);

    logic [bwam_pkg::SAMPLE_W-1:0] data_reg;

    // window starts out all zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            data_reg <= '0;
        end
        else if (shift_en)
        begin
            data_reg <= d;
        end
    end

    assign q = data_reg;

endmodule

`default_nettype wire

// ===== design/bwam_chain.sv =====
// ----------------------------------------------------------------------------
// Window chain
// Row of cells holding the last DEPTH samples of the interleaved stream; the
// far end is the sample that leaves the running sum.
// ----------------------------------------------------------------------------
`default_nettype none

module bwam_chain
#(
    parameter int DEPTH = bwam_pkg::CHANNEL_COUNT * bwam_pkg::WINDOW_LEN_DEFAULT
)
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           shift_en,
    input  wire logic [bwam_pkg::SAMPLE_W-1:0]  sample_in,
    output logic      [bwam_pkg::SAMPLE_W-1:0]  oldest
);

    logic [bwam_pkg::SAMPLE_W-1:0] tap [DEPTH+1];

    assign tap[0] = sample_in;

    // one cell per stored sample
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        bwam_cell u_cell
        (
            .clk      (clk),
            .rst_n    (rst_n),
            .shift_en (shift_en),
            .d        (tap[i]),
            .q        (tap[i+1])
        );
    end

    assign oldest = tap[DEPTH];

endmodule

`default_nettype wire

// ===== design/bwam_scale.sv =====
// ----------------------------------------------------------------------------
// Channel scaler
// Two registered stages: window average by reciprocal multiply, then average
// times full-scale millivolts shifted right 8.
// ----------------------------------------------------------------------------
`default_nettype none

module bwam_scale
#(
    parameter int WINDOW_LEN = bwam_pkg::WINDOW_LEN_DEFAULT,
    parameter int SUM_W      = bwam_pkg::SAMPLE_W + $clog2(WINDOW_LEN)
)
(
    input  wire logic                       clk,
    input  wire bwam_pkg::pipe_ctrl_t       ctrl,
    input  wire logic [SUM_W-1:0]           sum,
    input  wire logic [bwam_pkg::MV_W-1:0]  full_scale,
    output logic      [bwam_pkg::MV_W-1:0]  mv
);

    // ceil(2^K / N) with K = SUM_W + clog2(N) gives an exact floor for all sums
    localparam int DIV_SHIFT = SUM_W + $clog2(WINDOW_LEN);
    localparam int RECIP_W   = SUM_W + 1;
    localparam int PROD_W    = SUM_W + RECIP_W;
    localparam longint unsigned RECIP_VAL =
        ((64'd1 << DIV_SHIFT) + 64'(WINDOW_LEN) - 64'd1) / 64'(WINDOW_LEN);
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_VAL);
    localparam int SCALE_W = bwam_pkg::SAMPLE_W + bwam_pkg::MV_W;

    logic [PROD_W-1:0]              quot_prod;
    logic [bwam_pkg::SAMPLE_W-1:0]  avg_reg;
    logic [SCALE_W-1:0]             scale_prod;
    logic [bwam_pkg::MV_W-1:0]      mv_reg;

    // average of the window
    assign quot_prod = PROD_W'(sum) * PROD_W'(RECIP);

    always_ff @(posedge clk)
    begin
        if (ctrl.load_avg)
        begin
            avg_reg <= quot_prod[DIV_SHIFT +: bwam_pkg::SAMPLE_W];
        end
    end

    // millivolts, truncated
    assign scale_prod = SCALE_W'(avg_reg) * SCALE_W'(full_scale);

    always_ff @(posedge clk)
    begin
        if (ctrl.load_mv)
        begin
            mv_reg <= scale_prod[bwam_pkg::SAMPLE_W +: bwam_pkg::MV_W];
        end
    end

    assign mv = mv_reg;

endmodule

`default_nettype wire
